// ===== hw/rtl/voxel_cube_face_emitter_macros.svh =====
// Assertion macros used by the voxel cube face emitter checker.
`ifndef VOXEL_CUBE_FACE_EMITTER_MACROS_SVH
`define VOXEL_CUBE_FACE_EMITTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VCFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vcfe: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define VCFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vcfe: next-cycle check failed");

`endif

// ===== hw/rtl/vcfe_pkg.sv =====
// Package: constants, types and helpers of the voxel cube face emitter.
`default_nettype none
package vcfe_pkg;

  localparam int BLOCK_KINDS   = 256;
  localparam int MESH_VERTICES = 65536;
  localparam int FACES         = 6;
  localparam int CORNERS       = 6;

  localparam int UV_DEPTH = BLOCK_KINDS * FACES;
  localparam int UV_AW    = $clog2(UV_DEPTH);
  localparam int CNT_W    = $clog2(MESH_VERTICES + 1);

  typedef enum logic [1:0] {
    CMD_EMIT    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef logic [2:0] face_t;

  // One port group toward the UV table memory.
  typedef struct packed {
    logic             rd_en;
    logic [UV_AW-1:0] rd_addr;
    logic             wr_en;
    logic [UV_AW-1:0] wr_addr;
    logic [63:0]      wr_data;
  } uv_mem_req_t;

  // Corner code per face and corner: bit0 x, bit1 y, bit2 z offset,
  // bit3 u from far edge, bit4 v from far edge.
  localparam logic [4:0] CORNER_CODE [FACES*CORNERS] = '{
    5'd16, 5'd11, 5'd25, 5'd16, 5'd2,  5'd11,
    5'd20, 5'd29, 5'd15, 5'd20, 5'd15, 5'd6,
    5'd29, 5'd17, 5'd3,  5'd29, 5'd3,  5'd15,
    5'd28, 5'd2,  5'd16, 5'd28, 5'd14, 5'd2,
    5'd2,  5'd31, 5'd11, 5'd2,  5'd22, 5'd31,
    5'd0,  5'd9,  5'd29, 5'd0,  5'd29, 5'd20
  };

  function automatic logic [4:0] corner_code(input face_t face, input logic [2:0] corner);
    logic [5:0] idx;
    idx = 6'(int'(face) * CORNERS + int'(corner));
    return CORNER_CODE[idx];
  endfunction

  function automatic logic [UV_AW-1:0] uv_addr(input logic [7:0] blk, input face_t face);
    return UV_AW'(int'(blk) * FACES + int'(face));
  endfunction

  function automatic logic blk_valid(input logic [7:0] blk);
    return int'(blk) < BLOCK_KINDS;
  endfunction

  // Lowest visible face in a mask.
  function automatic face_t first_face(input logic [FACES-1:0] mask);
    face_t f;
    f = '0;
    for (int i = FACES - 1; i >= 0; i--) begin
      if (mask[i]) f = face_t'(i);
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/voxel_cube_face_emitter.sv =====
// Voxel cube face emitter: a load or restart item puts out no vertices. For an emit item, each
// visible face is handled in turn: a read state fetches its UV rectangle from the registered-read
// table memory, then an emit state puts out its six vertices through the output register, which
// stalls while the consumer holds ready low. Vertices come out face by face in ascending
// face_mask bit order;
// mesh_index counts across cubes until a restart item and saturates with overflow set at full
// mesh. The UV table has no reset: load every entry an emit will use before emitting.
`default_nettype none
module voxel_cube_face_emitter
  import vcfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [5:0]         face_mask,
  input  logic [7:0]         block_type,
  input  logic [2:0]         face_sel,
  input  logic [15:0]        uv_left,
  input  logic [15:0]        uv_top,
  input  logic [15:0]        uv_right,
  input  logic [15:0]        uv_bottom,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] vert_x,
  output logic signed [16:0] vert_y,
  output logic signed [16:0] vert_z,
  output logic [2:0]         normal_code,
  output logic [15:0]        tex_u,
  output logic [15:0]        tex_v,
  output logic [15:0]        mesh_index,
  output logic               overflow,
  output logic               last
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [15:0]       px, py, pz;
  logic [FACES-1:0]  mask_left;
  logic [FACES-1:0]  face_rest;
  face_t             face;
  logic [2:0]        corner;
  logic [7:0]        blk;
  logic              blk_ok;
  logic              in_fire, load, emit, rd_en;
  logic [4:0]        code;
  logic [63:0]       rd_data, rect;
  logic              full;
  logic [CNT_W-1:0]  slot;
  uv_mem_req_t       mem_req;

  assign in_fire   = in_valid && in_ready;
  assign load      = !out_valid || out_ready;
  assign face_rest = mask_left & ~(FACES'(1) << face);
  assign code      = corner_code(face, corner);
  assign rect      = blk_ok ? rd_data : '0;
  assign full      = count >= CNT_W'(MESH_VERTICES);
  assign slot      = full ? CNT_W'(MESH_VERTICES - 1) : count;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && cmd == CMD_EMIT && face_mask != '0) state_next = ST_READ;
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: begin
        if (load && corner == 3'(CORNERS - 1)) begin
          state_next = (face_rest == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    emit     = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_READ: rd_en = 1'b1;
      ST_EMIT: emit = load;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    mem_req.rd_en   = rd_en;
    mem_req.rd_addr = uv_addr(blk, face);
    mem_req.wr_en   = in_fire && cmd == CMD_LOAD && face_sel < 3'(FACES)
                      && blk_valid(block_type);
    mem_req.wr_addr = uv_addr(block_type, face_sel);
    mem_req.wr_data = {uv_bottom, uv_right, uv_top, uv_left};
  end

  vcfe_uv_mem u_uv_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire && cmd == CMD_RESTART) begin
        count <= '0;
      end else if (emit && !full) begin
        count <= count + CNT_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Cube registers and face/corner walk.
  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_EMIT) begin
      px        <= pos_x;
      py        <= pos_y;
      pz        <= pos_z;
      blk       <= block_type;
      blk_ok    <= blk_valid(block_type);
      mask_left <= face_mask;
      face      <= first_face(face_mask);
      corner    <= '0;
    end else if (emit) begin
      if (corner == 3'(CORNERS - 1)) begin
        mask_left <= face_rest;
        face      <= first_face(face_rest);
        corner    <= '0;
      end else begin
        corner <= corner + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      vert_x      <= {px[15], px} + 17'(code[0]);
      vert_y      <= {py[15], py} + 17'(code[1]);
      vert_z      <= {pz[15], pz} + 17'(code[2]);
      normal_code <= face;
      tex_u       <= code[3] ? rect[47:32] : rect[15:0];
      tex_v       <= code[4] ? rect[63:48] : rect[31:16];
      mesh_index  <= 16'(slot);
      overflow    <= full;
      last        <= (corner == 3'(CORNERS - 1)) && (face_rest == '0);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vcfe_uv_mem.sv =====
// UV rectangle table: one write port, one registered read port.
`default_nettype none
module vcfe_uv_mem
  import vcfe_pkg::*;
(
  input  logic        clk,
  input  uv_mem_req_t req,
  output logic [63:0] rd_data
);

  logic [63:0] mem [UV_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vcfe_checker.sv =====
// Port-level checker for the voxel cube face emitter, bound to the top level.
`default_nettype none
`include "voxel_cube_face_emitter_macros.svh"
module vcfe_checker
  import vcfe_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         cmd,
  input logic signed [15:0] pos_x,
  input logic signed [15:0] pos_y,
  input logic signed [15:0] pos_z,
  input logic [5:0]         face_mask,
  input logic [7:0]         block_type,
  input logic [2:0]         face_sel,
  input logic [15:0]        uv_left,
  input logic [15:0]        uv_top,
  input logic [15:0]        uv_right,
  input logic [15:0]        uv_bottom,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] vert_x,
  input logic signed [16:0] vert_y,
  input logic signed [16:0] vert_z,
  input logic [2:0]         normal_code,
  input logic [15:0]        tex_u,
  input logic [15:0]        tex_v,
  input logic [15:0]        mesh_index,
  input logic               overflow,
  input logic               last
);

  // Hold a stalled vertex.
  `VCFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(vert_x) && $stable(mesh_index) && $stable(last))

  // Accept no new item while a cube is still being put out.
  `VCFE_ASSERT_NOW(a_busy_mid_cube, out_valid && !last, !in_ready)

  // Saturate the slot at full mesh.
  `VCFE_ASSERT_NOW(a_ovf_slot, out_valid && overflow,
    mesh_index == 16'(MESH_VERTICES - 1))

  // Advance the slot by one within a cube.
  `VCFE_ASSERT_NEXT(a_slot_step, out_valid && out_ready && !last,
    !out_valid || overflow || mesh_index == $past(mesh_index) + 16'd1)

endmodule

bind voxel_cube_face_emitter vcfe_checker u_vcfe_checker (.*);
`default_nettype wire
